/* rtl/sbas_pkg.sv */
// Shared types and constants of the strobed bus access sequencer.
package sbas_pkg;

  localparam int unsigned AddrW      = 24;
  localparam int unsigned WordW      = 16;
  localparam int unsigned DataW      = 32;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  typedef enum logic [3:0] {
    CMD_WR16      = 4'd0,
    CMD_WR8       = 4'd1,
    CMD_WR32      = 4'd2,
    CMD_RD16      = 4'd3,
    CMD_RD8       = 4'd4,
    CMD_RD32      = 4'd5,
    CMD_STATUS_WR = 4'd6,
    CMD_STATUS_RD = 4'd7,
    CMD_SAMPLE    = 4'd8
  } cmd_e;

  typedef enum logic [2:0] {
    PH_WRITE     = 3'd0,
    PH_READ      = 3'd1,
    PH_IDLE      = 3'd2,
    PH_STATUS_RD = 3'd3,
    PH_ANSWER    = 3'd4,
    PH_ERROR     = 3'd5
  } phase_e;

  typedef enum logic [2:0] {
    SEL_W16    = 3'd0,
    SEL_R16    = 3'd1,
    SEL_W8     = 3'd2,
    SEL_R8     = 3'd3,
    SEL_STATUS = 3'd4
  } sel_e;

  typedef enum logic [2:0] {
    PEND_NONE   = 3'd0,
    PEND_R16    = 3'd1,
    PEND_R8     = 3'd2,
    PEND_R32_HI = 3'd3,
    PEND_R32_LO = 3'd4,
    PEND_STATUS = 3'd5
  } pend_e;

  // Kinds of work the back end carries out.
  typedef enum logic [2:0] {
    KIND_ERR   = 3'd0,
    KIND_ANS   = 3'd1,
    KIND_WR    = 3'd2,
    KIND_RD    = 3'd3,
    KIND_STWR  = 3'd4,
    KIND_STRD  = 3'd5
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    sel_e               sel;
    logic               dbl;
    logic [AddrW-1:0]   addr;
    logic [DataW-1:0]   data;
  } desc_t;

  typedef struct packed {
    phase_e             phase;
    sel_e               sel;
    logic [WordW-1:0]   word;
    logic [DataW-1:0]   rv;
    logic               last;
  } res_t;

endpackage

/* rtl/sbas_if.sv */
// Handshake interfaces for the command and result channels.
interface sbas_cmd_if;
  logic                        valid;
  logic                        ready;
  logic [3:0]                  command;
  logic [sbas_pkg::AddrW-1:0]  address;
  logic [sbas_pkg::DataW-1:0]  write_value;
  logic [sbas_pkg::WordW-1:0]  sampled_word;

  modport source (output valid, command, address, write_value, sampled_word, input ready);
  modport sink   (input valid, command, address, write_value, sampled_word, output ready);
endinterface

interface sbas_res_if;
  logic                        valid;
  logic                        ready;
  logic [2:0]                  phase;
  logic [2:0]                  reg_select;
  logic [sbas_pkg::WordW-1:0]  bus_word;
  logic [sbas_pkg::DataW-1:0]  read_value;
  logic                        last;

  modport source (output valid, phase, reg_select, bus_word, read_value, last, input ready);
  modport sink   (input valid, phase, reg_select, bus_word, read_value, last, output ready);
endinterface

/* rtl/sbas_front.sv */
// Front end: accepts commands and samples, tracks the pending read, issues work descriptors.
module sbas_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  sbas_cmd_if.sink            cmd_i,
  output logic                push_valid_o,
  input  logic                push_ready_i,
  output sbas_pkg::desc_t     push_desc_o
);

  sbas_pkg::pend_e                  pend_q, pend_d;
  logic [sbas_pkg::AddrW-1:0]       held_q, held_d;
  logic [sbas_pkg::WordW-1:0]       upper_q, upper_d;
  logic [sbas_pkg::AddrW-1:0]       held_plus2;
  logic [7:0]                       wbyte;
  logic                             busy;
  logic                             accept;
  sbas_pkg::desc_t                  desc;

  assign cmd_i.ready  = push_ready_i;
  assign push_valid_o = cmd_i.valid;
  assign push_desc_o  = desc;
  assign accept       = cmd_i.valid & push_ready_i;
  assign busy         = (pend_q != sbas_pkg::PEND_NONE);
  assign held_plus2   = held_q + sbas_pkg::AddrW'(2);
  assign wbyte        = cmd_i.write_value[7:0];

  always_comb begin
    pend_d  = pend_q;
    held_d  = held_q;
    upper_d = upper_q;
    desc.kind = sbas_pkg::KIND_ERR;
    desc.sel  = sbas_pkg::SEL_W16;
    desc.dbl  = 1'b0;
    desc.addr = cmd_i.address;
    desc.data = '0;
    if (cmd_i.command == sbas_pkg::CMD_SAMPLE) begin
      case (pend_q)
        sbas_pkg::PEND_R16, sbas_pkg::PEND_STATUS: begin
          desc.kind = sbas_pkg::KIND_ANS;
          desc.data = {16'h0000, cmd_i.sampled_word};
          pend_d    = sbas_pkg::PEND_NONE;
        end
        sbas_pkg::PEND_R8: begin
          desc.kind = sbas_pkg::KIND_ANS;
          desc.data = {24'h000000, held_q[0] ? cmd_i.sampled_word[7:0]
                                              : cmd_i.sampled_word[15:8]};
          pend_d    = sbas_pkg::PEND_NONE;
        end
        sbas_pkg::PEND_R32_HI: begin
          // The high half has arrived; chain the low-half read at address plus two.
          desc.kind = sbas_pkg::KIND_RD;
          desc.sel  = sbas_pkg::SEL_R16;
          desc.addr = held_plus2;
          upper_d   = cmd_i.sampled_word;
          held_d    = held_plus2;
          pend_d    = sbas_pkg::PEND_R32_LO;
        end
        sbas_pkg::PEND_R32_LO: begin
          desc.kind = sbas_pkg::KIND_ANS;
          desc.data = {upper_q, cmd_i.sampled_word};
          pend_d    = sbas_pkg::PEND_NONE;
        end
        default: begin
          desc.kind = sbas_pkg::KIND_ERR;
        end
      endcase
    end else if (!busy) begin
      case (cmd_i.command)
        sbas_pkg::CMD_WR16: begin
          desc.kind = sbas_pkg::KIND_WR;
          desc.data = {16'h0000, cmd_i.write_value[15:0]};
        end
        sbas_pkg::CMD_WR8: begin
          desc.kind = sbas_pkg::KIND_WR;
          desc.sel  = sbas_pkg::SEL_W8;
          desc.data = {16'h0000, cmd_i.address[0] ? {8'h00, wbyte} : {wbyte, wbyte}};
        end
        sbas_pkg::CMD_WR32: begin
          desc.kind = sbas_pkg::KIND_WR;
          desc.dbl  = 1'b1;
          desc.data = cmd_i.write_value;
        end
        sbas_pkg::CMD_RD16: begin
          desc.kind = sbas_pkg::KIND_RD;
          desc.sel  = sbas_pkg::SEL_R16;
          held_d    = cmd_i.address;
          pend_d    = sbas_pkg::PEND_R16;
        end
        sbas_pkg::CMD_RD8: begin
          desc.kind = sbas_pkg::KIND_RD;
          desc.sel  = sbas_pkg::SEL_R8;
          held_d    = cmd_i.address;
          pend_d    = sbas_pkg::PEND_R8;
        end
        sbas_pkg::CMD_RD32: begin
          desc.kind = sbas_pkg::KIND_RD;
          desc.sel  = sbas_pkg::SEL_R16;
          held_d    = cmd_i.address;
          pend_d    = sbas_pkg::PEND_R32_HI;
        end
        sbas_pkg::CMD_STATUS_WR: begin
          desc.kind = sbas_pkg::KIND_STWR;
          desc.sel  = sbas_pkg::SEL_STATUS;
          desc.data = {16'h0000, cmd_i.write_value[15:0]};
        end
        sbas_pkg::CMD_STATUS_RD: begin
          desc.kind = sbas_pkg::KIND_STRD;
          desc.sel  = sbas_pkg::SEL_STATUS;
          pend_d    = sbas_pkg::PEND_STATUS;
        end
        default: begin
          desc.kind = sbas_pkg::KIND_ERR;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q  <= sbas_pkg::PEND_NONE;
      held_q  <= '0;
      upper_q <= '0;
    end else if (accept) begin
      pend_q  <= pend_d;
      held_q  <= held_d;
      upper_q <= upper_d;
    end
  end

`ifndef SYNTH
  a_answer_clears_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && desc.kind == sbas_pkg::KIND_ANS |=> pend_q == sbas_pkg::PEND_NONE)
    else $error("pending read not cleared after an answer");
  a_busy_command_errors: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && busy && cmd_i.command != sbas_pkg::CMD_SAMPLE |-> desc.kind == sbas_pkg::KIND_ERR)
    else $error("command taken while a read was pending");
  a_error_keeps_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && desc.kind == sbas_pkg::KIND_ERR |=> $stable(pend_q) && $stable(held_q))
    else $error("error transfer changed the read state");
`endif

endmodule

/* rtl/sbas_queue.sv */
// Short descriptor queue between the front and back ends.
module sbas_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  sbas_pkg::desc_t   push_desc_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output sbas_pkg::desc_t   pop_desc_o
);

  sbas_pkg::desc_t                      mem_q [sbas_pkg::QueueDepth];
  logic [sbas_pkg::QueuePtrW-1:0]       wr_ptr_q, rd_ptr_q;
  logic [sbas_pkg::QueueCntW-1:0]       count_q;
  logic                                 push, pop;

  assign push_ready_o = (count_q != sbas_pkg::QueueCntW'(sbas_pkg::QueueDepth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_desc_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_desc_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == sbas_pkg::QueuePtrW'(sbas_pkg::QueueDepth - 1)) ? '0
                                                                             : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == sbas_pkg::QueuePtrW'(sbas_pkg::QueueDepth - 1)) ? '0
                                                                             : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

`ifndef SYNTH
  a_count_tracks_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop |=> count_q == $past(count_q) + 1'b1)
    else $error("queue fill count lost a transfer");
  a_count_tracks_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && !push |=> count_q == $past(count_q) - 1'b1)
    else $error("queue fill count repeated a transfer");
  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= sbas_pkg::QueueCntW'(sbas_pkg::QueueDepth))
    else $error("queue overfilled");
`endif

endmodule

/* rtl/sbas_back.sv */
// Back end: steps through the bus phases of each descriptor into the result register.
module sbas_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              desc_valid_i,
  output logic              desc_pop_o,
  input  sbas_pkg::desc_t   desc_i,
  sbas_res_if.source        res_o
);

  logic [2:0]                       step_q;
  logic                             res_valid_q;
  sbas_pkg::res_t                   res_q;
  sbas_pkg::res_t                   nxt;
  logic [sbas_pkg::AddrW-1:0]       addr_use;
  logic                             load;

  assign load       = desc_valid_i & (~res_valid_q | res_o.ready);
  assign desc_pop_o = load & nxt.last;
  // The second half of a 32-bit write goes to address plus two.
  assign addr_use   = step_q[2] ? desc_i.addr + sbas_pkg::AddrW'(2) : desc_i.addr;

  always_comb begin
    nxt.phase = sbas_pkg::PH_ERROR;
    nxt.sel   = sbas_pkg::SEL_W16;
    nxt.word  = '0;
    nxt.rv    = '0;
    nxt.last  = 1'b1;
    case (desc_i.kind)
      sbas_pkg::KIND_ANS: begin
        nxt.phase = sbas_pkg::PH_ANSWER;
        nxt.rv    = desc_i.data;
      end
      sbas_pkg::KIND_STWR: begin
        nxt.phase = sbas_pkg::PH_WRITE;
        nxt.sel   = desc_i.sel;
        nxt.word  = desc_i.data[15:0];
      end
      sbas_pkg::KIND_STRD: begin
        nxt.phase = sbas_pkg::PH_STATUS_RD;
        nxt.sel   = desc_i.sel;
      end
      sbas_pkg::KIND_WR, sbas_pkg::KIND_RD: begin
        nxt.sel  = desc_i.sel;
        nxt.last = 1'b0;
        case (step_q[1:0])
          2'd0: begin
            nxt.phase = sbas_pkg::PH_WRITE;
            nxt.word  = addr_use[15:0];
          end
          2'd1: begin
            nxt.phase = sbas_pkg::PH_WRITE;
            nxt.word  = {8'h00, addr_use[23:16]};
          end
          2'd2: begin
            if (desc_i.kind == sbas_pkg::KIND_RD) begin
              nxt.phase = sbas_pkg::PH_READ;
              nxt.last  = 1'b1;
            end else begin
              nxt.phase = sbas_pkg::PH_WRITE;
              nxt.word  = (desc_i.dbl && !step_q[2]) ? desc_i.data[31:16]
                                                       : desc_i.data[15:0];
            end
          end
          default: begin
            nxt.phase = sbas_pkg::PH_IDLE;
            nxt.last  = ~desc_i.dbl | step_q[2];
          end
        endcase
      end
      default: begin
        nxt.phase = sbas_pkg::PH_ERROR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (load) begin
        res_valid_q <= 1'b1;
        step_q      <= nxt.last ? 3'd0 : step_q + 3'd1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= nxt;
    end
  end

  assign res_o.valid      = res_valid_q;
  assign res_o.phase      = res_q.phase;
  assign res_o.reg_select = res_q.sel;
  assign res_o.bus_word   = res_q.word;
  assign res_o.read_value = res_q.rv;
  assign res_o.last       = res_q.last;

`ifndef SYNTH
  a_step_has_desc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q != 3'd0 |-> desc_valid_i)
    else $error("descriptor left the queue before its last phase");
  a_step_multi_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q != 3'd0 |-> desc_i.kind == sbas_pkg::KIND_WR || desc_i.kind == sbas_pkg::KIND_RD)
    else $error("phase counter running on a single-phase descriptor");
  a_pop_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    desc_pop_o |=> res_valid_q && res_q.last)
    else $error("descriptor popped without its last transfer");
`endif

endmodule

/* rtl/strobed_bus_access_sequencer.sv */
// Top level: strobed bus access sequencer, front end, descriptor queue and phase sequencer.
// Descriptors are registered in the queue and results in the back-end result register.
// The back-end sequencer gives one result per cycle while the result channel is ready; an
// item causes 1 (error, answer, status), 3 (read), 4 (write) or 8 (wr32) results.
// The two-entry descriptor queue lets commands be taken while results are still delivered.
// Reset clears the pending read, held address, upper half, the queue and the result valid.
module strobed_bus_access_sequencer (
  input  logic        clk_i,
  input  logic        rst_ni,
  sbas_cmd_if.sink    cmd_i,
  sbas_res_if.source  res_o
);

  logic               push_valid, push_ready;
  logic               pop_valid, pop_ready;
  sbas_pkg::desc_t    push_desc, pop_desc;

  sbas_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_desc_o  (push_desc)
  );

  sbas_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_desc_i  (push_desc),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_desc_o   (pop_desc)
  );

  sbas_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .desc_valid_i (pop_valid),
    .desc_pop_o   (pop_ready),
    .desc_i       (pop_desc),
    .res_o        (res_o)
  );

endmodule

/* sim/tb.sv */
// Self-checking testbench of the strobed bus access sequencer with a bus phase predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned RandomItems = 100;
  localparam int unsigned MaxReports  = 40;

  // Predicts the bus phases of each command and checks them in order of arrival.
  class access_phase_model;
    sbas_pkg::pend_e            pending;
    logic [sbas_pkg::AddrW-1:0] held_addr;
    logic [sbas_pkg::WordW-1:0] upper;
    sbas_pkg::res_t             due_phases[$];
    int unsigned                fails;
    int unsigned                checked;
    int unsigned                answers;
    int unsigned                errors;

    function new();
      pending   = sbas_pkg::PEND_NONE;
      held_addr = '0;
      upper     = '0;
      fails     = 0;
      checked   = 0;
      answers   = 0;
      errors    = 0;
    endfunction

    function int unsigned outstanding();
      return due_phases.size();
    endfunction

    function void add(sbas_pkg::phase_e ph, sbas_pkg::sel_e sel,
                      logic [sbas_pkg::WordW-1:0] word, logic [sbas_pkg::DataW-1:0] rv);
      sbas_pkg::res_t r;
      r.phase = ph;
      r.sel   = sel;
      r.word  = word;
      r.rv    = rv;
      r.last  = 1'b0;
      due_phases.push_back(r);
    endfunction

    function void addr_strobes(sbas_pkg::sel_e sel, logic [sbas_pkg::AddrW-1:0] addr);
      add(sbas_pkg::PH_WRITE, sel, addr[15:0], '0);
      add(sbas_pkg::PH_WRITE, sel, {8'h00, addr[23:16]}, '0);
    endfunction

    function void write_seq(sbas_pkg::sel_e sel, logic [sbas_pkg::AddrW-1:0] addr,
                            logic [sbas_pkg::WordW-1:0] word);
      addr_strobes(sel, addr);
      add(sbas_pkg::PH_WRITE, sel, word, '0);
      add(sbas_pkg::PH_IDLE, sel, '0, '0);
    endfunction

    function void read_seq(sbas_pkg::sel_e sel, logic [sbas_pkg::AddrW-1:0] addr);
      addr_strobes(sel, addr);
      add(sbas_pkg::PH_READ, sel, '0, '0);
    endfunction

    // Answer and error phases drive select zero, which is the write16 code.
    function void take_sample(logic [sbas_pkg::WordW-1:0] sw);
      case (pending)
        sbas_pkg::PEND_R16, sbas_pkg::PEND_STATUS: begin
          add(sbas_pkg::PH_ANSWER, sbas_pkg::SEL_W16, '0, {16'h0000, sw});
          pending = sbas_pkg::PEND_NONE;
        end
        sbas_pkg::PEND_R8: begin
          add(sbas_pkg::PH_ANSWER, sbas_pkg::SEL_W16, '0,
              {24'h000000, held_addr[0] ? sw[7:0] : sw[15:8]});
          pending = sbas_pkg::PEND_NONE;
        end
        sbas_pkg::PEND_R32_HI: begin
          upper     = sw;
          held_addr = held_addr + 24'd2;
          read_seq(sbas_pkg::SEL_R16, held_addr);
          pending   = sbas_pkg::PEND_R32_LO;
        end
        sbas_pkg::PEND_R32_LO: begin
          add(sbas_pkg::PH_ANSWER, sbas_pkg::SEL_W16, '0, {upper, sw});
          pending = sbas_pkg::PEND_NONE;
        end
        default: add(sbas_pkg::PH_ERROR, sbas_pkg::SEL_W16, '0, '0);
      endcase
    endfunction

    function void note_transfer(logic [3:0] code, logic [sbas_pkg::AddrW-1:0] addr,
                                logic [sbas_pkg::DataW-1:0] wv,
                                logic [sbas_pkg::WordW-1:0] sw);
      int unsigned first;
      logic [7:0]  b;
      first = due_phases.size();
      b     = wv[7:0];
      if (code == sbas_pkg::CMD_SAMPLE) begin
        take_sample(sw);
      end else if (code > sbas_pkg::CMD_SAMPLE || pending != sbas_pkg::PEND_NONE) begin
        add(sbas_pkg::PH_ERROR, sbas_pkg::SEL_W16, '0, '0);
      end else begin
        case (code)
          sbas_pkg::CMD_WR16: write_seq(sbas_pkg::SEL_W16, addr, wv[15:0]);
          sbas_pkg::CMD_WR8:  write_seq(sbas_pkg::SEL_W8, addr, addr[0] ? {8'h00, b} : {b, b});
          sbas_pkg::CMD_WR32: begin
            write_seq(sbas_pkg::SEL_W16, addr, wv[31:16]);
            write_seq(sbas_pkg::SEL_W16, addr + 24'd2, wv[15:0]);
          end
          sbas_pkg::CMD_RD16: begin
            read_seq(sbas_pkg::SEL_R16, addr);
            held_addr = addr;
            pending   = sbas_pkg::PEND_R16;
          end
          sbas_pkg::CMD_RD8: begin
            read_seq(sbas_pkg::SEL_R8, addr);
            held_addr = addr;
            pending   = sbas_pkg::PEND_R8;
          end
          sbas_pkg::CMD_RD32: begin
            read_seq(sbas_pkg::SEL_R16, addr);
            held_addr = addr;
            pending   = sbas_pkg::PEND_R32_HI;
          end
          sbas_pkg::CMD_STATUS_WR: add(sbas_pkg::PH_WRITE, sbas_pkg::SEL_STATUS, wv[15:0], '0);
          default: begin
            add(sbas_pkg::PH_STATUS_RD, sbas_pkg::SEL_STATUS, '0, '0);
            pending = sbas_pkg::PEND_STATUS;
          end
        endcase
      end
      if (due_phases.size() > first) due_phases[due_phases.size() - 1].last = 1'b1;
    endfunction

    function void report(string what, longint unsigned exp_v, longint unsigned got_v);
      fails++;
      if (fails <= MaxReports) begin
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, exp_v, got_v);
      end
    endfunction

    function void check_phase(sbas_pkg::res_t got);
      sbas_pkg::res_t exp_r;
      checked++;
      if (due_phases.size() == 0) begin
        fails++;
        if (fails <= MaxReports) begin
          $display("%0t: unexpected result, expected none, actual phase %0d word 0x%0h",
                   $time, got.phase, got.word);
        end
        return;
      end
      exp_r = due_phases.pop_front();
      if (exp_r.phase == sbas_pkg::PH_ANSWER) answers++;
      if (exp_r.phase == sbas_pkg::PH_ERROR) errors++;
      if (got.phase !== exp_r.phase) report("phase", exp_r.phase, got.phase);
      if (got.sel !== exp_r.sel) report("reg_select", exp_r.sel, got.sel);
      if (got.word !== exp_r.word) report("bus_word", exp_r.word, got.word);
      if (got.rv !== exp_r.rv) report("read_value", exp_r.rv, got.rv);
      if (got.last !== exp_r.last) report("last", exp_r.last, got.last);
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        no_idle;
  int unsigned items_sent;
  int unsigned cycles;

  access_phase_model phase_model;

  sbas_cmd_if cmd_bus();
  sbas_res_if res_bus();

  strobed_bus_access_sequencer DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_bus),
    .res_o  (res_bus)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Mostly short pauses, now and then a long one.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 92) return $urandom_range(3, 6);
    return $urandom_range(15, 40);
  endfunction

  function automatic int unsigned send_gap();
    if (no_idle || $urandom_range(0, 1) == 0) return 0;
    return idle_len();
  endfunction

  function automatic logic [sbas_pkg::AddrW-1:0] rand_addr();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 24'hfffffe | 24'($urandom_range(0, 1));
    if (r == 1) return 24'($urandom_range(0, 3));
    return 24'($urandom);
  endfunction

  task automatic send_item(logic [3:0] code, logic [sbas_pkg::AddrW-1:0] addr,
                           logic [sbas_pkg::DataW-1:0] wv, logic [sbas_pkg::WordW-1:0] sw);
    int unsigned gap;
    cmd_bus.valid        <= 1'b1;
    cmd_bus.command      <= code;
    cmd_bus.address      <= addr;
    cmd_bus.write_value  <= wv;
    cmd_bus.sampled_word <= sw;
    do @(posedge clk_i); while (cmd_bus.ready !== 1'b1);
    phase_model.note_transfer(code, addr, wv, sw);
    items_sent++;
    gap = send_gap();
    if (gap != 0) begin
      cmd_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_sample(logic [sbas_pkg::WordW-1:0] sw);
    send_item(sbas_pkg::CMD_SAMPLE, rand_addr(), $urandom, sw);
  endtask

  // A command that arrives while a read is still open; it must only give an error.
  task automatic maybe_intrude();
    if ($urandom_range(0, 7) == 0) send_item(4'($urandom_range(0, 7)), rand_addr(), $urandom,
                                             16'($urandom));
  endtask

  // A read command followed by the samples that it waits for.
  task automatic read_sequence(logic [3:0] code);
    int unsigned samples;
    samples = (code == sbas_pkg::CMD_RD32) ? 2 : 1;
    send_item(code, rand_addr(), $urandom, 16'($urandom));
    repeat (samples) begin
      maybe_intrude();
      send_sample(16'($urandom));
    end
  endtask

  task automatic random_access();
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 10)      send_item(sbas_pkg::CMD_WR16, rand_addr(), $urandom, 16'($urandom));
    else if (k < 20) send_item(sbas_pkg::CMD_WR8, rand_addr(), $urandom, 16'($urandom));
    else if (k < 30) send_item(sbas_pkg::CMD_WR32, rand_addr(), $urandom, 16'($urandom));
    else if (k < 42) read_sequence(sbas_pkg::CMD_RD16);
    else if (k < 54) read_sequence(sbas_pkg::CMD_RD8);
    else if (k < 68) read_sequence(sbas_pkg::CMD_RD32);
    else if (k < 74) send_item(sbas_pkg::CMD_STATUS_WR, rand_addr(), $urandom, 16'($urandom));
    else if (k < 84) read_sequence(sbas_pkg::CMD_STATUS_RD);
    else if (k < 91) send_sample(16'($urandom));
    else             send_item(4'($urandom_range(9, 15)), rand_addr(), $urandom, 16'($urandom));
  endtask

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("Timed out after %0d cycles with %0d results outstanding.",
               cycles, phase_model.outstanding());
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int unsigned stall;
    stall         = 0;
    res_bus.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall != 0) begin
        res_bus.ready <= 1'b0;
        stall--;
      end else begin
        res_bus.ready <= 1'b1;
        if (!no_idle && $urandom_range(0, 3) == 0) stall = idle_len();
      end
    end
  end

  always @(posedge clk_i) begin
    sbas_pkg::res_t got;
    if (rst_ni && res_bus.valid === 1'b1 && res_bus.ready === 1'b1) begin
      got.phase = sbas_pkg::phase_e'(res_bus.phase);
      got.sel   = sbas_pkg::sel_e'(res_bus.reg_select);
      got.word  = res_bus.bus_word;
      got.rv    = res_bus.read_value;
      got.last  = res_bus.last;
      phase_model.check_phase(got);
    end
  end

  initial begin
    int unsigned start;
    phase_model          = new();
    cycles               = 0;
    items_sent           = 0;
    no_idle              = 1'b0;
    rst_ni               = 1'b0;
    cmd_bus.valid        = 1'b0;
    cmd_bus.command      = sbas_pkg::CMD_WR16;
    cmd_bus.address      = '0;
    cmd_bus.write_value  = '0;
    cmd_bus.sampled_word = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: field extremes, byte lanes, address wrap and every error case.
    send_item(sbas_pkg::CMD_SAMPLE, 24'hffffff, 32'hffffffff, 16'hffff);
    send_item(sbas_pkg::CMD_WR16, 24'h000000, 32'h00000000, 16'h0000);
    send_item(sbas_pkg::CMD_WR16, 24'hffffff, 32'hffffffff, 16'h0000);
    send_item(sbas_pkg::CMD_WR8, 24'h123456, 32'h000000ab, 16'h0000);
    send_item(sbas_pkg::CMD_WR8, 24'h123457, 32'hffffffcd, 16'h0000);
    send_item(sbas_pkg::CMD_WR32, 24'hfffffe, 32'hdeadbeef, 16'h0000);
    send_item(sbas_pkg::CMD_RD16, 24'habcdef, 32'h0, 16'h0000);
    send_item(sbas_pkg::CMD_WR16, 24'h000100, 32'h1234, 16'h0000);
    send_item(sbas_pkg::CMD_SAMPLE, 24'h0, 32'h0, 16'hffff);
    send_item(sbas_pkg::CMD_RD8, 24'h000010, 32'h0, 16'h0000);
    send_item(sbas_pkg::CMD_SAMPLE, 24'h0, 32'h0, 16'h1234);
    send_item(sbas_pkg::CMD_RD8, 24'h000011, 32'h0, 16'h0000);
    send_item(sbas_pkg::CMD_SAMPLE, 24'h0, 32'h0, 16'h1234);
    send_item(sbas_pkg::CMD_RD32, 24'hfffffe, 32'h0, 16'h0000);
    send_item(sbas_pkg::CMD_SAMPLE, 24'h0, 32'h0, 16'h0000);
    send_item(sbas_pkg::CMD_RD16, 24'h000200, 32'h0, 16'h0000);
    send_item(sbas_pkg::CMD_SAMPLE, 24'h0, 32'h0, 16'hffff);
    send_item(sbas_pkg::CMD_STATUS_WR, 24'h0, 32'hffffffff, 16'h0000);
    send_item(sbas_pkg::CMD_STATUS_RD, 24'h0, 32'h0, 16'h0000);
    send_item(sbas_pkg::CMD_STATUS_RD, 24'h0, 32'h0, 16'h0000);
    send_item(sbas_pkg::CMD_SAMPLE, 24'h0, 32'h0, 16'ha5a5);
    send_item(4'd9, 24'h0, 32'h0, 16'h0000);
    send_item(4'd15, 24'hffffff, 32'hffffffff, 16'hffff);
    send_item(sbas_pkg::CMD_STATUS_WR, 24'h0, 32'h0, 16'h0000);

    // Random part: mostly complete accesses, some stray samples and intruding commands.
    start = items_sent;
    while (items_sent - start < RandomItems) begin
      no_idle = (items_sent - start >= 40) && (items_sent - start < 60);
      random_access();
    end
    no_idle = 1'b0;
    cmd_bus.valid <= 1'b0;

    while (phase_model.outstanding() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Sent %0d commands and samples; checked %0d bus phases,", items_sent,
             phase_model.checked);
    $display("of which %0d were read answers and %0d were error phases.",
             phase_model.answers, phase_model.errors);
    if (phase_model.fails == 0 && phase_model.outstanding() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
